// ----- design/skl_pkg.sv -----
// skl_pkg: shared constants, command and status codes and control types
// for the sorted key list unit. no dependencies.
`default_nettype none

package skl_pkg;

	localparam int CAPACITY  = 64;
	localparam int KEY_WIDTH = 32;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_CLEAR  = 2'd3
	} skl_cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} skl_status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} skl_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic exec;
	} skl_ctl_t;

endpackage

`default_nettype wire

// ----- design/skl_ctrl.sv -----
// skl_ctrl: controller state machine for the sorted key list unit,
// handles both handshakes and sequences the datapath. depends on skl_pkg.
`default_nettype none

module skl_ctrl import skl_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output skl_ctl_t      ctl
);

	skl_state_t state_q, state_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ctl.load_in = 1'b0;
		ctl.exec    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				ctl.load_in = in_valid;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// wait for the result register to free up
				if (!out_valid_q || out_ready) begin
					ctl.exec    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- design/skl_dp.sv -----
// skl_dp: datapath of the sorted key list unit, a row of key cells that
// compare in parallel and shift, plus fill count and result registers. depends on skl_pkg.
`default_nettype none

module skl_dp import skl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  skl_ctl_t         ctl,
	input  wire logic [1:0]  cmd,
	input  wire logic [31:0] key,
	output logic [1:0]       status,
	output logic             hit,
	output logic [6:0]       element_count
);

	skl_cmd_t               cmd_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [CNT_W-1:0]       fill_q, fill_d;
	logic [KEY_WIDTH-1:0]   entry_q [CAPACITY];
	logic [KEY_WIDTH-1:0]   entry_d [CAPACITY];
	skl_status_t            status_q, status_d;
	logic                   hit_q, hit_d;

	logic [CAPACITY-1:0]    act, lt, le, eq;
	logic                   found, full, empty, ins_ok, rem_ok;

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= skl_cmd_t'(cmd);
			key_q <= KEY_WIDTH'(key);
		end
	end

	// per cell compare against the held key
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign act[i] = CNT_W'(i) < fill_q;
		assign lt[i]  = act[i] && (entry_q[i] <  key_q);
		assign le[i]  = act[i] && (entry_q[i] <= key_q);
		assign eq[i]  = act[i] && (entry_q[i] == key_q);

		if (i == 0) begin : g_first
			assign entry_d[i] = ins_ok ? (le[i] ? entry_q[i] : key_q)
				: (rem_ok ? (lt[i] ? entry_q[i] : entry_q[i+1]) : entry_q[i]);
		end else if (i == CAPACITY - 1) begin : g_last
			assign entry_d[i] = ins_ok
				? (le[i] ? entry_q[i] : (le[i-1] ? key_q : entry_q[i-1]))
				: entry_q[i];
		end else begin : g_mid
			assign entry_d[i] = ins_ok
				? (le[i] ? entry_q[i] : (le[i-1] ? key_q : entry_q[i-1]))
				: (rem_ok ? (lt[i] ? entry_q[i] : entry_q[i+1]) : entry_q[i]);
		end
	end

	assign found  = |eq;
	assign full   = fill_q == CNT_W'(CAPACITY);
	assign empty  = fill_q == '0;
	assign ins_ok = (cmd_q == CMD_INSERT) && !full;
	assign rem_ok = (cmd_q == CMD_REMOVE) && found;

	always_comb begin
		status_d = ST_OK;
		hit_d    = 1'b0;
		fill_d   = fill_q;
		case (cmd_q)
			CMD_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					hit_d  = 1'b1;
					fill_d = fill_q + CNT_W'(1);
				end
			end
			CMD_REMOVE, CMD_SEARCH: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (found) begin
					hit_d = 1'b1;
					if (rem_ok) begin
						fill_d = fill_q - CNT_W'(1);
					end
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			CMD_CLEAR: begin
				fill_d = '0;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.exec) begin
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q <= status_d;
			hit_q    <= hit_d;
			for (int k = 0; k < CAPACITY; k++) begin
				entry_q[k] <= entry_d[k];
			end
		end
	end

	assign status        = status_q;
	assign hit           = hit_q;
	assign element_count = 7'(fill_q);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && cmd_q == CMD_CLEAR |=> fill_q == '0)
		else $error("clear did not empty the list");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> (!hit_q || status_q == ST_OK))
		else $error("hit with error status");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && cmd_q == CMD_INSERT && full |=> $stable(fill_q))
		else $error("insert into full store changed count");

endmodule

`default_nettype wire

// ----- design/sorted_key_list_unit.sv -----
// sorted_key_list_unit: top level of the sorted key list unit, joins the
// controller and the datapath. depends on skl_pkg, skl_ctrl, skl_dp.
//
// usage: one input transaction (cmd, key) on in_valid/in_ready gives one
// result transaction (status, hit, element_count) on out_valid/out_ready.
// commands are insert, remove one copy, search and clear; keys are held in
// ascending order in a row of cells that all compare with the key at once
// and shift by one place in the same cycle.
// the input is registered when accepted, and the result register is written
// in the execute step once that register is free. the cell row handles one
// transaction at a time: the accept step, then the compare-and-shift step.
// a new input is accepted while a finished result still waits; if the
// receiver stalls, that next item waits in the execute step until the
// result register is taken, and no further input is accepted meanwhile.
// reset empties the list (count zero) and drops any pending result; the
// cell contents are not cleared, entries past the count are never used.
`default_nettype none

module sorted_key_list_unit import skl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [31:0] key,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             hit,
	output logic [6:0]       element_count
);

	skl_ctl_t ctl;

	skl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	skl_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cmd           (cmd),
		.key           (key),
		.status        (status),
		.hit           (hit),
		.element_count (element_count)
	);

endmodule

`default_nettype wire
